/* hw/rtl/sacls_pkg.sv */
// Shared types and constants for the set-associative cache tag model.
// No dependencies; imported by every module of the block.
package sacls_pkg;

  localparam int unsigned MaxSetBitsDef = 6;
  localparam int unsigned MaxWaysDef    = 8;
  localparam int unsigned AddrWidthDef  = 32;
  localparam int unsigned CountWidth    = 32;
  localparam int unsigned CfgWidth      = 5;
  localparam int unsigned CfgIdxWidth   = 2;

  // Trace command codes.
  localparam logic [1:0] CmdLoad   = 2'd0;
  localparam logic [1:0] CmdStore  = 2'd1;
  localparam logic [1:0] CmdModify = 2'd2;
  localparam logic [1:0] CmdFetch  = 2'd3;

  // Configuration register indexes.
  localparam logic [CfgIdxWidth-1:0] RegSetBits  = 2'd0;
  localparam logic [CfgIdxWidth-1:0] RegOffBits  = 2'd1;
  localparam logic [CfgIdxWidth-1:0] RegWays     = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch address, decode set and tag
    logic rd_set;   // read the addressed set
    logic update;   // compare, choose victim, write back, count
  } sacls_cmd_t;

endpackage

/* hw/rtl/sacls_ctrl.sv */
// Controller state machine: sequences lookups for each trace transaction.
// Depends on sacls_pkg.
module sacls_ctrl
  import sacls_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       init_done_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] command_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       last_o,
  output sacls_cmd_t cmd_o
);

  typedef enum logic [1:0] {StIdle, StRead, StUpdate, StOut} state_e;

  state_e state_q, state_d;
  logic   second_q, second_d;   // a second lookup of a modify is pending
  logic   last_q, last_d;

  // Input is held off until the datapath has finished clearing its storage.
  assign in_ready_o  = (state_q == StIdle) && init_done_i;
  assign out_valid_o = (state_q == StOut);
  assign last_o      = last_q;

  // Next-state and command decode.
  always_comb begin
    state_d  = state_q;
    second_d = second_q;
    last_d   = last_q;
    cmd_o    = '0;
    unique case (state_q)
      StIdle: begin
        if (in_ready_o && in_valid_i && command_i != CmdFetch) begin
          cmd_o.capture = 1'b1;
          second_d      = (command_i == CmdModify);
          state_d       = StRead;
        end
      end
      StRead: begin
        cmd_o.rd_set = 1'b1;
        state_d      = StUpdate;
      end
      StUpdate: begin
        cmd_o.update = 1'b1;
        last_d       = !second_q;
        state_d      = StOut;
      end
      StOut: begin
        if (out_ready_i) begin
          if (second_q) begin
            second_d = 1'b0;
            state_d  = StRead;
          end else begin
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // State and registered flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      second_q <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      second_q <= second_d;
      last_q   <= last_d;
    end
  end

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o)) else $error("more than one datapath command");
  a_upd_then_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.update |=> out_valid_o) else $error("update not followed by result");
  a_read_then_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_set |=> cmd_o.update) else $error("read not followed by update");

endmodule

/* hw/rtl/sacls_dpath.sv */
// Datapath: tag, valid and age storage, lookup, LRU update and totals.
// Depends on sacls_pkg.
module sacls_dpath
  import sacls_pkg::*;
#(
  parameter int unsigned MaxSetBits = MaxSetBitsDef,
  parameter int unsigned MaxWays    = MaxWaysDef,
  parameter int unsigned AddrWidth  = AddrWidthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sacls_cmd_t            cmd_i,
  input  logic [2:0]            set_bits_i,
  input  logic [4:0]            off_bits_i,
  input  logic [3:0]            ways_i,
  input  logic [31:0]           address_i,
  output logic                  init_done_o,
  output logic                  hit_o,
  output logic                  evicted_o,
  output logic [CountWidth-1:0] hit_total_o,
  output logic [CountWidth-1:0] miss_total_o,
  output logic [CountWidth-1:0] evict_total_o
);

  localparam int unsigned NumSets = 1 << MaxSetBits;
  localparam int unsigned SetW    = (MaxSetBits > 0) ? MaxSetBits : 1;
  localparam int unsigned WayW    = (MaxWays > 1) ? $clog2(MaxWays) : 1;
  localparam int unsigned RankW   = WayW;
  localparam int unsigned WaysW   = $clog2(MaxWays + 1);
  localparam logic [RankW-1:0] RankMax = RankW'(MaxWays - 1);

  // One row per set: all ways side by side.
  logic [MaxWays-1:0][AddrWidth-1:0] tag_mem [NumSets];
  logic [MaxWays-1:0][RankW-1:0]     rank_mem [NumSets];
  logic [MaxWays-1:0]                vld_mem [NumSets];

  logic [SetW-1:0]      set_q;
  logic [AddrWidth-1:0] tag_q;
  logic [MaxWays-1:0][AddrWidth-1:0] tag_rd_q;
  logic [MaxWays-1:0][RankW-1:0]     rank_rd_q;
  logic [MaxWays-1:0]                vld_rd_q;
  logic [WaysW-1:0]     nways_q;

  // Clearing pass after reset: one set per cycle.
  logic            clr_q;
  logic [SetW-1:0] clr_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_idx_q <= '0;
    end else if (clr_q) begin
      clr_idx_q <= clr_idx_q + 1'b1;
      if (clr_idx_q == SetW'(NumSets - 1)) clr_q <= 1'b0;
    end
  end

  assign init_done_o = !clr_q;

  // Effective settings and address decode.
  logic [3:0]            s_eff;
  logic [WaysW-1:0]      nways_d;
  logic [AddrWidth-1:0]  a_shift;
  logic [AddrWidth-1:0]  set_mask;
  always_comb begin
    s_eff = (32'(set_bits_i) > MaxSetBits) ? 4'(MaxSetBits) : {1'b0, set_bits_i};
    if (ways_i == 4'd0)                 nways_d = WaysW'(1);
    else if (32'(ways_i) > MaxWays)     nways_d = WaysW'(MaxWays);
    else                                nways_d = WaysW'(ways_i);
    a_shift  = AddrWidth'(address_i) >> off_bits_i;
    set_mask = (AddrWidth'(1) << s_eff) - AddrWidth'(1);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      set_q   <= SetW'(a_shift & set_mask);
      tag_q   <= a_shift >> s_eff;
      nways_q <= nways_d;
    end
  end

  // Registered read of the addressed row.
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_set) begin
      tag_rd_q  <= tag_mem[set_q];
      rank_rd_q <= rank_mem[set_q];
      vld_rd_q  <= vld_mem[set_q];
    end
  end

  // Compare, victim choice and new ranks.
  logic [MaxWays-1:0] in_use, match, live, vld_new;
  logic               hit, found, evict;
  logic [WayW-1:0]    way;
  logic [WayW-1:0]    hit_way, inv_way, old_way;
  logic [MaxWays-1:0][RankW-1:0] rank_new;
  logic [RankW-1:0]   old_rank;
  always_comb begin
    hit = 1'b0; found = 1'b0;
    hit_way = '0; inv_way = '0; old_way = '0;
    for (int i = 0; i < MaxWays; i++) begin
      in_use[i] = (i < nways_q);
      live[i]   = in_use[i] && vld_rd_q[i];
      match[i]  = live[i] && (tag_rd_q[i] == tag_q);
    end
    for (int i = MaxWays - 1; i >= 0; i--) begin
      if (match[i]) begin hit = 1'b1; hit_way = WayW'(i); end
      if (in_use[i] && !vld_rd_q[i]) begin found = 1'b1; inv_way = WayW'(i); end
    end
    for (int i = 1; i < MaxWays; i++) begin
      if (in_use[i] && rank_rd_q[i] > rank_rd_q[old_way]) old_way = WayW'(i);
    end
    evict = !hit && !found;
    way   = hit ? hit_way : (found ? inv_way : old_way);
    old_rank = rank_rd_q[way];
    vld_new  = vld_rd_q;
    vld_new[way] = 1'b1;
    for (int i = 0; i < MaxWays; i++) begin
      rank_new[i] = rank_rd_q[i];
      if (WayW'(i) == way) begin
        rank_new[i] = '0;
      end else if (live[i] && (!vld_rd_q[way] || rank_rd_q[i] < old_rank)
                   && rank_rd_q[i] != RankMax) begin
        rank_new[i] = rank_rd_q[i] + RankW'(1);
      end
    end
  end

  // Clear the valid bits and ages of each row after reset, then write back the row on update.
  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      vld_mem[clr_idx_q]  <= '0;
      rank_mem[clr_idx_q] <= '0;
    end else if (cmd_i.update) begin
      vld_mem[set_q]  <= vld_new;
      rank_mem[set_q] <= rank_new;
      if (!hit) tag_mem[set_q][way] <= tag_q;
    end
  end

  // Outcome flags and saturating totals.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_o         <= 1'b0;
      evicted_o     <= 1'b0;
      hit_total_o   <= '0;
      miss_total_o  <= '0;
      evict_total_o <= '0;
    end else if (cmd_i.update) begin
      hit_o     <= hit;
      evicted_o <= evict;
      if (hit && hit_total_o != '1) hit_total_o <= hit_total_o + 1'b1;
      if (!hit && miss_total_o != '1) miss_total_o <= miss_total_o + 1'b1;
      if (evict && evict_total_o != '1) evict_total_o <= evict_total_o + 1'b1;
    end
  end

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update |=> !(hit_o && evicted_o)) else $error("hit and eviction together");
  a_evict_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update && evict |-> &(vld_rd_q | ~in_use)) else $error("eviction with a free way");
  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> (cmd_i == '0)) else $error("command during clearing pass");

endmodule

/* hw/rtl/set_assoc_cache_lru_sim_unit.sv */
// Top level of the set-associative cache tag model with LRU replacement.
// Depends on sacls_pkg, sacls_ctrl and sacls_dpath.
//
// Each trace transaction takes its command and address; load and store give
// one result, modify gives two, instruction fetch gives none. A lookup runs
// through capture, set read, and update with write back, and then waits for
// the output handshake; a modify's second lookup reuses the captured address.
// A new transaction is accepted only once the previous one has handed over
// all of its results. After reset a clearing pass over every set clears the
// valid bits and ages; input is held off until it ends. Settings written
// through the configuration port take effect at the next transaction.
module set_assoc_cache_lru_sim_unit
  import sacls_pkg::*;
#(
  parameter int unsigned MaxSetBits = MaxSetBitsDef,
  parameter int unsigned MaxWays    = MaxWaysDef,
  parameter int unsigned AddrWidth  = AddrWidthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [CfgWidth-1:0]    cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             command_i,
  input  logic [31:0]            address_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   access_hit_o,
  output logic                   access_evicted_o,
  output logic                   last_of_run_o,
  output logic [CountWidth-1:0]  hit_total_o,
  output logic [CountWidth-1:0]  miss_total_o,
  output logic [CountWidth-1:0]  eviction_total_o
);

  logic [2:0] set_bits_q;
  logic [4:0] off_bits_q;
  logic [3:0] ways_q;
  sacls_cmd_t cmd;
  logic       init_done;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q <= 3'd4;
      off_bits_q <= 5'd4;
      ways_q     <= 4'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegSetBits: set_bits_q <= cfg_data_i[2:0];
        RegOffBits: off_bits_q <= cfg_data_i;
        RegWays:    ways_q     <= cfg_data_i[3:0];
        default:    ;
      endcase
    end
  end

  sacls_ctrl u_ctrl (
    .clk_i, .rst_ni, .init_done_i(init_done), .in_valid_i, .in_ready_o, .command_i,
    .out_valid_o, .out_ready_i, .last_o(last_of_run_o), .cmd_o(cmd)
  );

  sacls_dpath #(
    .MaxSetBits(MaxSetBits), .MaxWays(MaxWays), .AddrWidth(AddrWidth)
  ) u_dpath (
    .clk_i, .rst_ni, .cmd_i(cmd),
    .set_bits_i(set_bits_q), .off_bits_i(off_bits_q), .ways_i(ways_q),
    .address_i, .init_done_o(init_done),
    .hit_o(access_hit_o), .evicted_o(access_evicted_o),
    .hit_total_o, .miss_total_o, .evict_total_o(eviction_total_o)
  );

endmodule
